/* rtl/core/ihws_pkg.sv */
// Shared types, constants and helpers for the inverse Haar shrink block.
// No dependencies; imported by every module of the block except ihws_ram.
package ihws_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH_LOG2  = 6;
    localparam int DEF_MAX_HEIGHT_LOG2 = 6;
    localparam int DEF_COEF_BITS       = 20;

    // Fixed field widths of the configuration registers
    localparam int LOG_BITS      = 3;
    localparam int MODE_BITS     = 2;
    localparam int TH_BITS       = 19;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 19;

    // Register reset values
    localparam logic [LOG_BITS-1:0] RST_WIDTH_LOG2  = 3'd6;
    localparam logic [LOG_BITS-1:0] RST_HEIGHT_LOG2 = 3'd6;
    localparam logic [LOG_BITS-1:0] RST_LEVELS      = 3'd1;
    localparam logic [TH_BITS-1:0]  RST_THRESHOLD   = 19'd800;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WIDTH_LOG2  = 3'd0,
        REG_HEIGHT_LOG2 = 3'd1,
        REG_LEVELS      = 3'd2,
        REG_SHRINK_MODE = 3'd3,
        REG_THRESHOLD   = 3'd4
    } t_reg_idx;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NONE    = 2'd0,
        MODE_HARD    = 2'd1,
        MODE_SOFT    = 2'd2,
        MODE_GARROTE = 2'd3
    } t_mode;

    typedef enum logic {
        PH_LOAD  = 1'b0,
        PH_READY = 1'b1
    } t_phase;

    typedef enum logic [2:0] {
        E_IDLE,
        E_INIT,
        E_RD,
        E_SH,
        E_SW,
        E_WR,
        E_CP,
        E_CPF
    } t_eng_state;

    typedef struct packed {
        logic [LOG_BITS-1:0] width_log2;
        logic [LOG_BITS-1:0] height_log2;
        logic [LOG_BITS-1:0] levels;
        t_mode               shrink_mode;
        logic [TH_BITS-1:0]  threshold;
    } t_cfg;

    // Clamp a log2 size register to 1..max_log
    function automatic logic [LOG_BITS-1:0] clamp_log(input logic [LOG_BITS-1:0] v,
                                                     input int max_log);
        logic [LOG_BITS-1:0] res;
        res = v;
        if (v == '0) begin
            res = LOG_BITS'(1);
        end else if (int'(v) > max_log) begin
            res = LOG_BITS'(max_log);
        end
        return res;
    endfunction

endpackage

/* rtl/core/ihws_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ihws_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ihws_shrink.sv */
// Detail shrink unit: none, hard, soft and garrote, with an iterative
// restoring divider for T*T/|d|. Depends on ihws_pkg.
module ihws_shrink #(
    parameter int COEF_BITS = ihws_pkg::DEF_COEF_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  ihws_pkg::t_mode                    i_mode,
    input  logic signed [COEF_BITS-1:0]        i_d,
    input  logic [ihws_pkg::TH_BITS-1:0]       i_t,
    input  logic [2*ihws_pkg::TH_BITS-1:0]     i_tt,
    output logic                               o_done,
    output logic signed [COEF_BITS-1:0]        o_r
);
    import ihws_pkg::*;

    localparam int W    = ((COEF_BITS > TH_BITS) ? COEF_BITS : TH_BITS) + 1;
    localparam int CNTW = $clog2(TH_BITS + 1);

    logic signed [W-1:0]  w_dx;
    logic [W-1:0]         w_ad;
    logic [W-1:0]         w_t;
    logic [W-1:0]         w_soft;
    logic [W-1:0]         w_mag;
    logic [W:0]           w_trial;
    logic                 w_ge;
    logic [TH_BITS-1:0]   w_q;

    logic                 r_busy;
    logic                 r_done;
    logic [CNTW-1:0]      r_cnt;
    logic [W-1:0]         r_rem;
    logic [TH_BITS-1:0]   r_lo;
    logic [TH_BITS-1:0]   r_q;
    logic [W-1:0]         r_ad;
    logic                 r_neg;
    logic signed [COEF_BITS-1:0] r_r;

    // Magnitude and one divider step
    always_comb begin
        w_dx    = W'(i_d);
        w_ad    = w_dx[W-1] ? W'(-w_dx) : W'(w_dx);
        w_t     = W'(i_t);
        w_soft  = w_ad - w_t;
        w_trial = {r_rem, r_lo[TH_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_ad});
        w_q     = {r_q[TH_BITS-2:0], w_ge};
        w_mag   = r_ad - W'(w_q);
    end

    // Control: divider busy flag, count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_mode == MODE_GARROTE && w_ad > w_t) begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNTW'(TH_BITS);
                end else begin
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: result and divider registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= W'(i_tt[2*TH_BITS-1:TH_BITS]);
            r_lo  <= i_tt[TH_BITS-1:0];
            r_q   <= '0;
            r_ad  <= w_ad;
            r_neg <= w_dx[W-1];
            case (i_mode)
                MODE_NONE: r_r <= i_d;
                MODE_HARD: r_r <= (w_ad > w_t) ? i_d : '0;
                MODE_SOFT: begin
                    if (w_ad > w_t) begin
                        r_r <= w_dx[W-1] ? COEF_BITS'(-w_soft) : COEF_BITS'(w_soft);
                    end else begin
                        r_r <= '0;
                    end
                end
                default: r_r <= '0;
            endcase
        end else if (r_busy) begin
            r_rem <= w_ge ? W'(w_trial - {1'b0, r_ad}) : W'(w_trial);
            r_lo  <= r_lo << 1;
            r_q   <= w_q;
            if (r_cnt == CNTW'(1)) begin
                r_r <= r_neg ? COEF_BITS'(-w_mag) : COEF_BITS'(w_mag);
            end
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

endmodule

/* rtl/core/ihws_engine.sv */
// Transform sequencer: walks quads level by level, reads the coefficient
// store, shrinks, writes pixels to the work store and copies them back.
// Depends on ihws_pkg, ihws_ram and ihws_shrink.
module ihws_engine #(
    parameter int MAX_WIDTH_LOG2  = ihws_pkg::DEF_MAX_WIDTH_LOG2,
    parameter int MAX_HEIGHT_LOG2 = ihws_pkg::DEF_MAX_HEIGHT_LOG2,
    parameter int COEF_BITS       = ihws_pkg::DEF_COEF_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  ihws_pkg::t_cfg                               i_cfg,
    output logic                                         o_busy,
    output logic                                         o_coef_re,
    output logic [MAX_WIDTH_LOG2+MAX_HEIGHT_LOG2-1:0]    o_coef_raddr,
    input  logic [COEF_BITS-1:0]                         i_coef_rdata,
    output logic                                         o_coef_we,
    output logic [MAX_WIDTH_LOG2+MAX_HEIGHT_LOG2-1:0]    o_coef_waddr,
    output logic [COEF_BITS-1:0]                         o_coef_wdata
);
    import ihws_pkg::*;

    localparam int AW    = MAX_WIDTH_LOG2 + MAX_HEIGHT_LOG2;
    localparam int DEPTH = 1 << AW;

    t_eng_state r_state, n_state;

    logic [LOG_BITS-1:0]        w_ew, w_eh, w_lv;
    logic [AW-1:0]              w_w, w_base, w_vrow, w_top, w_rd_addr, w_wr_addr;
    logic [AW-1:0]              w_cw, w_ch;
    logic                       w_quad_last, w_copy_last;
    logic signed [COEF_BITS+1:0] w_c, w_h, w_v, w_d, w_sum;
    logic signed [COEF_BITS:0]  w_half;
    logic [COEF_BITS-1:0]       w_pix;

    localparam logic signed [COEF_BITS:0] SAT_MAX = {2'b00, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS:0] SAT_MIN = {2'b11, {(COEF_BITS-1){1'b0}}};

    logic [LOG_BITS-1:0]        r_k;
    logic [AW-1:0]              r_hw, r_hh, r_x, r_y;
    logic [1:0]                 r_e;
    logic [2*TH_BITS-1:0]       r_tt;
    logic signed [COEF_BITS-1:0] r_val [4];
    logic                       r_cp_v;
    logic [AW-1:0]              r_cp_addr;

    logic                       w_work_we, w_work_re;
    logic [AW-1:0]              w_work_raddr;
    logic [COEF_BITS-1:0]       w_work_rdata;
    logic                       w_sh_start, w_sh_done;
    t_mode                      w_sh_mode;
    logic signed [COEF_BITS-1:0] w_sh_r;

    // Effective sizes and level count
    always_comb begin
        w_ew = clamp_log(i_cfg.width_log2, MAX_WIDTH_LOG2);
        w_eh = clamp_log(i_cfg.height_log2, MAX_HEIGHT_LOG2);
        w_lv = i_cfg.levels;
        if (w_lv > w_ew) w_lv = w_ew;
        if (w_lv > w_eh) w_lv = w_eh;
    end

    // Quad and copy addressing
    always_comb begin
        w_w    = AW'(1) << w_ew;
        w_base = AW'(r_y << w_ew) + r_x;
        w_vrow = AW'((r_y + r_hh) << w_ew) + r_x;
        w_top  = AW'((r_y << 1) << w_ew) + AW'(r_x << 1);
        w_cw   = r_hw << 1;
        w_ch   = r_hh << 1;
        w_quad_last = (r_x == r_hw - 1'b1) && (r_y == r_hh - 1'b1);
        w_copy_last = (r_x == w_cw - 1'b1) && (r_y == w_ch - 1'b1);
        case (r_e)
            2'd0:    w_rd_addr = w_base;
            2'd1:    w_rd_addr = w_base + r_hw;
            2'd2:    w_rd_addr = w_vrow;
            default: w_rd_addr = w_vrow + r_hw;
        endcase
        case (r_e)
            2'd0:    w_wr_addr = w_top;
            2'd1:    w_wr_addr = w_top + AW'(1);
            2'd2:    w_wr_addr = w_top + w_w;
            default: w_wr_addr = w_top + w_w + AW'(1);
        endcase
    end

    // Butterfly for the pixel selected by r_e, floor half and saturate
    always_comb begin
        w_c = (COEF_BITS+2)'(r_val[0]);
        w_h = (COEF_BITS+2)'(r_val[1]);
        w_v = (COEF_BITS+2)'(r_val[2]);
        w_d = (COEF_BITS+2)'(r_val[3]);
        case (r_e)
            2'd0:    w_sum = w_c + w_h + w_v + w_d;
            2'd1:    w_sum = w_c - w_h + w_v - w_d;
            2'd2:    w_sum = w_c + w_h - w_v - w_d;
            default: w_sum = w_c - w_h - w_v + w_d;
        endcase
        w_half = w_sum[COEF_BITS+1:1];
        if (w_half > SAT_MAX) begin
            w_pix = SAT_MAX[COEF_BITS-1:0];
        end else if (w_half < SAT_MIN) begin
            w_pix = SAT_MIN[COEF_BITS-1:0];
        end else begin
            w_pix = w_half[COEF_BITS-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: if (i_start && w_lv != '0) n_state = E_INIT;
            E_INIT: n_state = E_RD;
            E_RD:   n_state = E_SH;
            E_SH:   n_state = E_SW;
            E_SW:   if (w_sh_done) n_state = (r_e == 2'd3) ? E_WR : E_RD;
            E_WR:   if (r_e == 2'd3) n_state = w_quad_last ? E_CP : E_RD;
            E_CP:   if (w_copy_last) n_state = E_CPF;
            E_CPF:  n_state = (r_k == LOG_BITS'(1)) ? E_IDLE : E_RD;
            default: n_state = E_IDLE;
        endcase
    end

    // Memory and unit controls
    always_comb begin
        o_busy       = (r_state != E_IDLE);
        o_coef_re    = (r_state == E_RD);
        o_coef_raddr = w_rd_addr;
        o_coef_we    = r_cp_v;
        o_coef_waddr = r_cp_addr;
        o_coef_wdata = w_work_rdata;
        w_work_we    = (r_state == E_WR);
        w_work_re    = (r_state == E_CP);
        w_work_raddr = w_base;
        w_sh_start   = (r_state == E_SH);
        w_sh_mode    = (r_e == 2'd0) ? MODE_NONE : i_cfg.shrink_mode;
    end

    // State and copy-write valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_cp_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cp_v  <= (r_state == E_CP);
        end
    end

    // Counters, level registers and quad operands
    always_ff @(posedge i_clk) begin
        r_cp_addr <= w_base;
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    r_k  <= w_lv;
                    r_hw <= (AW'(1) << w_ew) >> w_lv;
                    r_hh <= (AW'(1) << w_eh) >> w_lv;
                    r_x  <= '0;
                    r_y  <= '0;
                    r_e  <= '0;
                end
            end
            E_INIT: r_tt <= (2*TH_BITS)'(i_cfg.threshold) * (2*TH_BITS)'(i_cfg.threshold);
            E_SW: begin
                if (w_sh_done) begin
                    r_val[r_e] <= w_sh_r;
                    r_e        <= r_e + 1'b1;
                end
            end
            E_WR: begin
                r_e <= r_e + 1'b1;
                if (r_e == 2'd3) begin
                    if (w_quad_last) begin
                        r_x <= '0;
                        r_y <= '0;
                    end else if (r_x == r_hw - 1'b1) begin
                        r_x <= '0;
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
            end
            E_CP: begin
                if (w_copy_last) begin
                    r_x <= '0;
                    r_y <= '0;
                end else if (r_x == w_cw - 1'b1) begin
                    r_x <= '0;
                    r_y <= r_y + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            E_CPF: begin
                r_k  <= r_k - 1'b1;
                r_hw <= r_hw << 1;
                r_hh <= r_hh << 1;
            end
            default: ;
        endcase
    end

    ihws_shrink #(
        .COEF_BITS (COEF_BITS)
    ) u_shrink (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sh_start),
        .i_mode  (w_sh_mode),
        .i_d     (i_coef_rdata),
        .i_t     (i_cfg.threshold),
        .i_tt    (r_tt),
        .o_done  (w_sh_done),
        .o_r     (w_sh_r)
    );

    ihws_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (DEPTH)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_work_we),
        .i_waddr (w_wr_addr),
        .i_wdata (w_pix),
        .i_re    (w_work_re),
        .i_raddr (w_work_raddr),
        .o_rdata (w_work_rdata)
    );

endmodule

/* rtl/core/inverse_haar_wavelet_shrink.sv */
// Top level of the inverse Haar shrink block: stream ports, configuration
// registers, load and readout. Depends on ihws_pkg, ihws_ram, ihws_engine.
//
//  Channel  | Direction | Payload                           | Transfer when
//  s_axis   | in        | tdata: coefficient; tuser: opcode | tvalid & tready
//  m_axis   | out       | tdata: pixel; tlast: last_pixel   | tvalid & tready
//  cfg      | in        | index, data                       | valid & ready
//
// A load is a single RAM write. A read goes through address, RAM read and output
// register. After the last load the transform runs from the coefficient RAM:
// each quad is read, shrunk (garrote details through the divider) and written,
// then each level is copied back. Input is stalled during it.
// Reset is synchronous, active low, and clears control state only.
module inverse_haar_wavelet_shrink #(
    parameter int MAX_WIDTH_LOG2  = ihws_pkg::DEF_MAX_WIDTH_LOG2,
    parameter int MAX_HEIGHT_LOG2 = ihws_pkg::DEF_MAX_HEIGHT_LOG2,
    parameter int COEF_BITS       = ihws_pkg::DEF_COEF_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // s_axis: tdata = coefficient, zero padded to bytes; tuser = opcode
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((COEF_BITS+7)/8)*8-1:0]        i_s_axis_tdata,
    input  logic                                  i_s_axis_tuser,
    // m_axis: tdata = pixel, zero padded to bytes; tlast = last_pixel
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((COEF_BITS+7)/8)*8-1:0]        o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ihws_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ihws_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import ihws_pkg::*;

    localparam int AW  = MAX_WIDTH_LOG2 + MAX_HEIGHT_LOG2;
    localparam int CW  = AW + 1;
    localparam int TDW = ((COEF_BITS + 7) / 8) * 8;

    t_cfg                 r_cfg;
    t_phase               r_phase;
    logic [CW-1:0]        r_load_index;
    logic [CW-1:0]        r_read_index;
    logic                 r_rd_pend;
    logic                 r_rd_last;
    logic                 r_ov;
    logic                 r_last;
    logic [COEF_BITS-1:0] r_pix;

    logic [LOG_BITS-1:0]  w_ew, w_eh;
    logic [CW-1:0]        w_n, w_ld_idx, w_ld_next, w_ri, w_ri_next;
    logic                 w_acc, w_ld, w_rd, w_start, w_busy;

    logic                 w_eng_re, w_eng_we;
    logic [AW-1:0]        w_eng_raddr, w_eng_waddr;
    logic [COEF_BITS-1:0] w_eng_wdata;
    logic                 w_ram_re, w_ram_we;
    logic [AW-1:0]        w_ram_raddr, w_ram_waddr;
    logic [COEF_BITS-1:0] w_ram_wdata, w_ram_rdata;

    // Image size and load/read indexes
    always_comb begin
        w_ew      = clamp_log(r_cfg.width_log2, MAX_WIDTH_LOG2);
        w_eh      = clamp_log(r_cfg.height_log2, MAX_HEIGHT_LOG2);
        w_n       = CW'(1) << ({1'b0, w_ew} + {1'b0, w_eh});
        w_ld_idx  = (r_phase == PH_READY) ? '0 : r_load_index;
        w_ld_next = w_ld_idx + 1'b1;
        w_ri      = (r_read_index >= w_n) ? '0 : r_read_index;
        w_ri_next = w_ri + 1'b1;
    end

    // Input handshake: hold off during transform, while a read is in flight and, for a read, while an output is held
    assign o_s_axis_tready = !w_busy && !r_rd_pend &&
                             !(i_s_axis_tuser && (r_phase == PH_READY) && r_ov);
    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ld    = w_acc && !i_s_axis_tuser;
    assign w_rd    = w_acc && i_s_axis_tuser && (r_phase == PH_READY);
    assign w_start = w_ld && (w_ld_next >= w_n);

    // Coefficient RAM port sharing between load/readout and the engine
    always_comb begin
        if (w_busy) begin
            w_ram_we    = w_eng_we;
            w_ram_waddr = w_eng_waddr;
            w_ram_wdata = w_eng_wdata;
            w_ram_re    = w_eng_re;
            w_ram_raddr = w_eng_raddr;
        end else begin
            w_ram_we    = w_ld;
            w_ram_waddr = w_ld_idx[AW-1:0];
            w_ram_wdata = i_s_axis_tdata[COEF_BITS-1:0];
            w_ram_re    = w_rd;
            w_ram_raddr = w_ri[AW-1:0];
        end
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_log2  <= RST_WIDTH_LOG2;
            r_cfg.height_log2 <= RST_HEIGHT_LOG2;
            r_cfg.levels      <= RST_LEVELS;
            r_cfg.shrink_mode <= MODE_NONE;
            r_cfg.threshold   <= RST_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WIDTH_LOG2:  r_cfg.width_log2  <= i_cfg_data[LOG_BITS-1:0];
                REG_HEIGHT_LOG2: r_cfg.height_log2 <= i_cfg_data[LOG_BITS-1:0];
                REG_LEVELS:      r_cfg.levels      <= i_cfg_data[LOG_BITS-1:0];
                REG_SHRINK_MODE: r_cfg.shrink_mode <= t_mode'(i_cfg_data[MODE_BITS-1:0]);
                REG_THRESHOLD:   r_cfg.threshold   <= i_cfg_data[TH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Load and read indexes, phase, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LOAD;
            r_load_index <= '0;
            r_read_index <= '0;
            r_rd_pend    <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_rd_pend <= w_rd;
            if (w_ld) begin
                if (w_start) begin
                    r_load_index <= '0;
                    r_read_index <= '0;
                    r_phase      <= PH_READY;
                end else begin
                    r_load_index <= w_ld_next;
                    r_phase      <= PH_LOAD;
                end
            end else if (w_rd) begin
                r_read_index <= (w_ri_next >= w_n) ? '0 : w_ri_next;
            end
            if (r_rd_pend) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rd_last <= (w_ri == w_n - 1'b1);
        end
        if (r_rd_pend) begin
            r_pix  <= w_ram_rdata;
            r_last <= r_rd_last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = TDW'(r_pix);
    assign o_m_axis_tlast  = r_last;

    ihws_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (1 << AW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    ihws_engine #(
        .MAX_WIDTH_LOG2  (MAX_WIDTH_LOG2),
        .MAX_HEIGHT_LOG2 (MAX_HEIGHT_LOG2),
        .COEF_BITS       (COEF_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_cfg        (r_cfg),
        .o_busy       (w_busy),
        .o_coef_re    (w_eng_re),
        .o_coef_raddr (w_eng_raddr),
        .i_coef_rdata (w_ram_rdata),
        .o_coef_we    (w_eng_we),
        .o_coef_waddr (w_eng_waddr),
        .o_coef_wdata (w_eng_wdata)
    );

    // A new output only follows a RAM read that was pending the cycle before
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_rd_pend))
        else $error("output valid without a pending read");

    // No input transfer while the transform owns the coefficient RAM
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_s_axis_tready)
        else $error("input accepted during transform");

    // A pending read does not overlap another and sets output valid in the cycle after
    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> (!r_rd_pend && r_ov))
        else $error("read pending overlap or lost");

endmodule
